FILE: rtl/ttps_pkg.sv
// Shared types and constants for the transposition table probe/store block.
// No dependencies; imported by the controller, datapath and top level.
package ttps_pkg;

   // Slot count; must be a power of two, the slot is the low key bits.
   localparam int TABLE_ENTRIES = 4096;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);

   localparam logic OP_PROBE = 1'b0;
   localparam logic OP_STORE = 1'b1;

   localparam logic [1:0] BOUND_EXACT = 2'd0;
   localparam logic [1:0] BOUND_LOWER = 2'd1;
   localparam logic [1:0] BOUND_UPPER = 2'd2;

   typedef struct packed {
      logic [63:0]        key;
      logic [15:0]        move;
      logic signed [15:0] score;
      logic signed [7:0]  depth;
      logic [1:0]         bound;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_wr;   // write a zero slot at the sweep counter
      logic capture;    // take the request beat, read its slot
      logic evaluate;   // slot data is back: decide, write, register result
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
   } dp_status_type;

endpackage

FILE: rtl/ttps_ram.sv
// Generic single-port RAM with registered read data (read-before-write).
// No dependencies; used by the datapath for the slot store.
module ttps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ttps_ctrl.sv
// Controller FSM: clearing sweep after reset, then accept / lookup sequencing.
// Depends on ttps_pkg.
module ttps_ctrl import ttps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy
);

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      busy         = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.evaluate = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_capture_then_eval: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.evaluate)
      else $error("accepted beat not evaluated next cycle");

   a_eval_single: assert property (@(posedge clock) disable iff (reset)
      cmd.evaluate |=> !cmd.evaluate && !cmd.clear_wr)
      else $error("evaluate not followed by idle");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_wr |-> busy && !cmd.capture)
      else $error("beat accepted during clear sweep");

endmodule

FILE: rtl/ttps_dp.sv
// Datapath: request registers, slot RAM, clear counter, hit/bound logic and
// result registers. Depends on ttps_pkg and ttps_ram.
module ttps_dp import ttps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output dp_status_type      status,
   input  logic               req_opcode,
   input  logic [63:0]        req_position_key,
   input  logic [15:0]        req_move_in,
   input  logic signed [15:0] req_score_in,
   input  logic signed [7:0]  req_search_depth,
   input  logic [1:0]         req_bound_kind,
   input  logic signed [15:0] req_window_low,
   input  logic signed [15:0] req_window_high,
   output logic               rsp_strobe,
   output logic               rsp_hit,
   output logic [15:0]        rsp_move_out,
   output logic               rsp_cutoff,
   output logic signed [15:0] rsp_cutoff_score,
   output logic signed [15:0] rsp_window_low_out,
   output logic signed [15:0] rsp_window_high_out,
   output logic               rsp_written
);

   // request beat
   logic               op_ff;
   logic [63:0]        key_ff;
   logic [15:0]        move_ff;
   logic signed [15:0] score_ff;
   logic signed [7:0]  depth_ff;
   logic [1:0]         bound_ff;
   logic signed [15:0] wlo_ff;
   logic signed [15:0] whi_ff;

   logic [IDX_W-1:0]   clr_cnt_ff, clr_cnt_in;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_addr;
   entry_type          ram_wdata;
   entry_type          slot;

   logic               key_match, replace, usable, cut;
   logic signed [15:0] lo, hi;

   logic               valid_ff, valid_in;
   logic               hit_ff, hit_in;
   logic [15:0]        mv_ff, mv_in;
   logic               cut_ff, cut_in;
   logic signed [15:0] cscore_ff, cscore_in;
   logic signed [15:0] lo_ff, lo_in;
   logic signed [15:0] hi_ff, hi_in;
   logic               wr_ff, wr_in;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         key_ff   <= req_position_key;
         move_ff  <= req_move_in;
         score_ff <= req_score_in;
         depth_ff <= req_search_depth;
         bound_ff <= req_bound_kind;
         wlo_ff   <= req_window_low;
         whi_ff   <= req_window_high;
      end
   end

   assign clr_cnt_in        = cmd.clear_wr ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
   assign status.clear_last = (clr_cnt_ff == IDX_W'(TABLE_ENTRIES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // slot decision
   always_comb begin
      key_match = (slot.key == key_ff);
      replace   = !key_match || (depth_ff >= slot.depth);
      usable    = key_match && (slot.depth >= depth_ff);
      lo        = wlo_ff;
      hi        = whi_ff;
      cut       = 1'b0;
      if (usable) begin
         if (slot.bound == BOUND_EXACT) begin
            cut = 1'b1;
         end else begin
            if (slot.bound == BOUND_LOWER && slot.score > wlo_ff) begin
               lo = slot.score;
            end
            if (slot.bound == BOUND_UPPER && slot.score < whi_ff) begin
               hi = slot.score;
            end
            cut = (lo >= hi);
         end
      end
   end

   always_comb begin
      ram_wdata.key   = key_ff;
      ram_wdata.move  = move_ff;
      ram_wdata.score = score_ff;
      ram_wdata.depth = depth_ff;
      ram_wdata.bound = bound_ff;
      ram_we          = cmd.evaluate && (op_ff == OP_STORE) && replace;
      ram_addr        = req_position_key[IDX_W-1:0];
      if (cmd.clear_wr) begin
         ram_wdata = '0;
         ram_we    = 1'b1;
         ram_addr  = clr_cnt_ff;
      end else if (cmd.evaluate) begin
         ram_addr = key_ff[IDX_W-1:0];
      end
   end

   ttps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (slot)
   );

   // result beat
   always_comb begin
      valid_in  = cmd.evaluate;
      hit_in    = 1'b0;
      mv_in     = '0;
      cut_in    = 1'b0;
      cscore_in = '0;
      lo_in     = '0;
      hi_in     = '0;
      wr_in     = 1'b0;
      if (op_ff == OP_STORE) begin
         wr_in = replace;
      end else begin
         hit_in    = key_match;
         mv_in     = key_match ? slot.move : '0;
         cut_in    = cut;
         cscore_in = cut ? slot.score : '0;
         lo_in     = lo;
         hi_in     = hi;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.evaluate) begin
         hit_ff    <= hit_in;
         mv_ff     <= mv_in;
         cut_ff    <= cut_in;
         cscore_ff <= cscore_in;
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         wr_ff     <= wr_in;
      end
   end

   assign rsp_strobe          = valid_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_move_out        = mv_ff;
   assign rsp_cutoff          = cut_ff;
   assign rsp_cutoff_score    = cscore_ff;
   assign rsp_window_low_out  = lo_ff;
   assign rsp_window_high_out = hi_ff;
   assign rsp_written         = wr_ff;

   a_eval_write_is_store: assert property (@(posedge clock) disable iff (reset)
      (cmd.evaluate && ram_we) |-> (op_ff == OP_STORE))
      else $error("slot written by a probe");

   a_cut_needs_hit: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && cut_ff) |-> hit_ff && !wr_ff)
      else $error("cutoff without hit");

endmodule

FILE: rtl/transposition_table_probe_store.sv
// Direct-mapped transposition table: 4096 slots picked by the low 12 key bits.
// After reset the block sweeps zeros into every slot, one per cycle, while busy
// stays high. Then for each beat (start while busy low) the slot is read in the
// accept cycle, compared and, for a store, rewritten in the next; the single
// result beat is registered from that evaluation and shows on rsp_* with
// rsp_strobe high for one cycle, while busy is already low again. The
// single-port slot RAM sets the pace: a new beat waits while one is evaluated.
// Results cannot be held off; capture them on the strobe.
module transposition_table_probe_store import ttps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic [63:0]        req_position_key,
   input  logic [15:0]        req_move_in,
   input  logic signed [15:0] req_score_in,
   input  logic signed [7:0]  req_search_depth,
   input  logic [1:0]         req_bound_kind,
   input  logic signed [15:0] req_window_low,
   input  logic signed [15:0] req_window_high,
   output logic               rsp_strobe,
   output logic               rsp_hit,
   output logic [15:0]        rsp_move_out,
   output logic               rsp_cutoff,
   output logic signed [15:0] rsp_cutoff_score,
   output logic signed [15:0] rsp_window_low_out,
   output logic signed [15:0] rsp_window_high_out,
   output logic               rsp_written
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   ttps_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   ttps_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_opcode          (req_opcode),
      .req_position_key    (req_position_key),
      .req_move_in         (req_move_in),
      .req_score_in        (req_score_in),
      .req_search_depth    (req_search_depth),
      .req_bound_kind      (req_bound_kind),
      .req_window_low      (req_window_low),
      .req_window_high     (req_window_high),
      .rsp_strobe          (rsp_strobe),
      .rsp_hit             (rsp_hit),
      .rsp_move_out        (rsp_move_out),
      .rsp_cutoff          (rsp_cutoff),
      .rsp_cutoff_score    (rsp_cutoff_score),
      .rsp_window_low_out  (rsp_window_low_out),
      .rsp_window_high_out (rsp_window_high_out),
      .rsp_written         (rsp_written)
   );

   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 2))
      else $error("result beat without accepted request");

endmodule

FILE: verif/transposition_table_probe_store_checker.sv
// Checker for transposition_table_probe_store: mirrors the slot table, predicts each
// result beat from the accepted request beats and compares it field by field.
// Depends on ttps_pkg for the entry layout, opcodes and bound kinds.
module transposition_table_probe_store_checker import ttps_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_opcode,
   input  logic [63:0]        req_position_key,
   input  logic [15:0]        req_move_in,
   input  logic signed [15:0] req_score_in,
   input  logic signed [7:0]  req_search_depth,
   input  logic [1:0]         req_bound_kind,
   input  logic signed [15:0] req_window_low,
   input  logic signed [15:0] req_window_high,
   input  logic               rsp_strobe,
   input  logic               rsp_hit,
   input  logic [15:0]        rsp_move_out,
   input  logic               rsp_cutoff,
   input  logic signed [15:0] rsp_cutoff_score,
   input  logic signed [15:0] rsp_window_low_out,
   input  logic signed [15:0] rsp_window_high_out,
   input  logic               rsp_written,
   output int                 fail_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               hit;
      logic [15:0]        move;
      logic               cutoff;
      logic signed [15:0] cutoff_score;
      logic signed [15:0] window_low;
      logic signed [15:0] window_high;
      logic               written;
   } outcome_type;

   entry_type   slot_mirror [TABLE_ENTRIES];
   outcome_type awaited_outcomes [$];
   int          mismatches = 0;

   assign fail_count = mismatches;

   task automatic report_mismatch(string msg);
      if (mismatches < 100) begin
         $display("%0t ns: MISMATCH %s", $time, msg);
      end
      mismatches++;
   endtask

   task automatic check_field(string field, int got_v, int want_v);
      if (got_v != want_v) begin
         report_mismatch($sformatf("%s got %0d expected %0d", field, got_v, want_v));
      end
   endtask

   // Applies one beat to the mirror and returns the result it should produce.
   function automatic outcome_type resolve_beat(
      logic op, logic [63:0] key, logic [15:0] mv, logic signed [15:0] sc,
      logic signed [7:0] dep, logic [1:0] bnd,
      logic signed [15:0] lo_in, logic signed [15:0] hi_in);
      outcome_type        r;
      entry_type          e;
      logic [IDX_W-1:0]   slot;
      logic signed [15:0] lo;
      logic signed [15:0] hi;
      r = '0;
      slot = key[IDX_W-1:0];
      e = slot_mirror[slot];
      lo = lo_in;
      hi = hi_in;
      if (op == OP_STORE) begin
         // replace on a foreign key, or when at least as deep as what is there
         if (e.key != key || dep >= e.depth) begin
            e.key   = key;
            e.move  = mv;
            e.score = sc;
            e.depth = dep;
            e.bound = bnd;
            slot_mirror[slot] = e;
            r.written = 1'b1;
         end
         return r;
      end
      if (e.key == key) begin
         r.hit  = 1'b1;
         r.move = e.move;
         if (e.depth >= dep) begin
            if (e.bound == BOUND_EXACT) begin
               r.cutoff = 1'b1;
            end else begin
               // bound kind three tightens nothing; a closed window still cuts
               if (e.bound == BOUND_LOWER && e.score > lo) lo = e.score;
               if (e.bound == BOUND_UPPER && e.score < hi) hi = e.score;
               if (lo >= hi) r.cutoff = 1'b1;
            end
            if (r.cutoff) r.cutoff_score = e.score;
         end
      end
      r.window_low  = lo;
      r.window_high = hi;
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) slot_mirror[i] = '0;
         awaited_outcomes.delete();
      end else begin
         if (rsp_strobe) begin
            if (awaited_outcomes.size() == 0) begin
               report_mismatch("result beat with no request outstanding");
            end else begin
               want = awaited_outcomes.pop_front();
               check_field("hit", int'(rsp_hit), int'(want.hit));
               check_field("move_out", int'(rsp_move_out), int'(want.move));
               check_field("cutoff", int'(rsp_cutoff), int'(want.cutoff));
               check_field("cutoff_score", int'(rsp_cutoff_score),
                           int'(want.cutoff_score));
               check_field("window_low_out", int'(rsp_window_low_out),
                           int'(want.window_low));
               check_field("window_high_out", int'(rsp_window_high_out),
                           int'(want.window_high));
               check_field("written", int'(rsp_written), int'(want.written));
            end
         end
         if (start && !busy) begin
            awaited_outcomes.push_back(resolve_beat(
               req_opcode, req_position_key, req_move_in, req_score_in,
               req_search_depth, req_bound_kind, req_window_low, req_window_high));
         end
      end
      pending_count <= awaited_outcomes.size();
   end

endmodule

FILE: verif/transposition_table_probe_store_tb.sv
// Top of the transposition_table_probe_store testbench: clock, reset, directed and
// random probe/store beats with random gaps, watchdog and verdict.
// Depends on ttps_pkg, the block, and transposition_table_probe_store_checker.
module transposition_table_probe_store_tb import ttps_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BEATS = 600;
   localparam int STALL_LIMIT  = 20000;  // covers the clearing sweep after reset
   localparam int KEY_POOL_N   = 16;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_opcode;
   logic [63:0]        req_position_key;
   logic [15:0]        req_move_in;
   logic signed [15:0] req_score_in;
   logic signed [7:0]  req_search_depth;
   logic [1:0]         req_bound_kind;
   logic signed [15:0] req_window_low;
   logic signed [15:0] req_window_high;
   logic               rsp_strobe;
   logic               rsp_hit;
   logic [15:0]        rsp_move_out;
   logic               rsp_cutoff;
   logic signed [15:0] rsp_cutoff_score;
   logic signed [15:0] rsp_window_low_out;
   logic signed [15:0] rsp_window_high_out;
   logic               rsp_written;
   int                 fail_count;
   int                 pending_count;

   int                 stall_cycles = 0;
   int                 burst_left = 0;
   logic [63:0]        key_pool [KEY_POOL_N];

   transposition_table_probe_store dut (.*);

   transposition_table_probe_store_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("transposition_table_probe_store_tb failed");
         $finish;
      end
   end

   // Gap after a beat: mostly none or short, a few long, sometimes a gapless run.
   task automatic idle_after_beat();
      int gap;
      int pick;
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         pick = $urandom_range(99);
         if (pick < 5) burst_left = $urandom_range(40, 15);
         else if (pick < 40) gap = 0;
         else if (pick < 92) gap = $urandom_range(3, 1);
         else gap = $urandom_range(60, 8);
      end
      if (gap > 0) begin
         start            <= 1'b0;
         req_opcode       <= 1'($urandom_range(1));
         req_position_key <= {$urandom, $urandom};
         req_score_in     <= 16'($urandom);
         req_window_low   <= 16'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_beat(logic op, logic [63:0] key, logic [15:0] mv,
                            logic signed [15:0] sc, logic signed [7:0] dep,
                            logic [1:0] bnd, logic signed [15:0] lo,
                            logic signed [15:0] hi);
      start            <= 1'b1;
      req_opcode       <= op;
      req_position_key <= key;
      req_move_in      <= mv;
      req_score_in     <= sc;
      req_search_depth <= dep;
      req_bound_kind   <= bnd;
      req_window_low   <= lo;
      req_window_high  <= hi;
      @(posedge clock);
      while (busy) @(posedge clock);
      idle_after_beat();
   endtask

   task automatic send_random_beat();
      logic        op;
      logic [63:0] key;
      logic [1:0]  bnd;
      int          sc;
      int          dep;
      int          lo;
      int          hi;
      op  = 1'($urandom_range(1));
      key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL_N - 1)]
                                      : {$urandom, $urandom};
      sc  = ($urandom_range(99) < 80) ? int'($urandom_range(800)) - 400 : int'($urandom);
      dep = ($urandom_range(99) < 80) ? int'($urandom_range(10)) - 2 : int'($urandom);
      bnd = ($urandom_range(99) < 8) ? 2'd3 : 2'($urandom_range(2));
      if ($urandom_range(99) < 85) begin
         lo = int'($urandom_range(1000)) - 500;
         hi = lo + int'($urandom_range(700)) - 100;
      end else begin
         lo = int'($urandom);
         hi = int'($urandom);
      end
      send_beat(op, key, 16'($urandom), 16'(sc), 8'(dep), bnd, 16'(lo), 16'(hi));
   endtask

   initial begin
      reset            <= 1'b1;
      start            <= 1'b0;
      req_opcode       <= OP_PROBE;
      req_position_key <= '0;
      req_move_in      <= '0;
      req_score_in     <= '0;
      req_search_depth <= '0;
      req_bound_kind   <= BOUND_EXACT;
      req_window_low   <= '0;
      req_window_high  <= '0;
      // several keys share each of a few slots so replacements and misses are common
      key_pool[0] = '0;
      for (int i = 1; i < KEY_POOL_N; i++) begin
         key_pool[i] = {$urandom, $urandom};
         key_pool[i][IDX_W-1:0] = IDX_W'($urandom_range(5));
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // cleared slots: key 0 hits an exact, depth-0 entry of score 0
      send_beat(OP_PROBE, 64'd0, 16'd0, 16'sd0, 8'sd0, BOUND_EXACT, -16'sd5, 16'sd5);
      send_beat(OP_PROBE, 64'd0, 16'd0, 16'sd0, 8'sd1, BOUND_EXACT, -16'sd5, 16'sd5);
      send_beat(OP_PROBE, 64'd0, 16'd0, 16'sd0, -8'sd128, BOUND_EXACT, 16'sd7, -16'sd7);
      send_beat(OP_PROBE, 64'h1000, 16'd0, 16'sd0, 8'sd0, BOUND_EXACT, -16'sd1, 16'sd1);
      // exact entry, deep enough and too shallow; replacement by depth
      send_beat(OP_STORE, 64'h1234_0001, 16'h0abc, 16'sd100, 8'sd5, BOUND_EXACT,
                16'sd0, 16'sd0);
      send_beat(OP_PROBE, 64'h1234_0001, 16'd0, 16'sd0, 8'sd5, BOUND_LOWER, 16'sd200,
                16'sd100);
      send_beat(OP_PROBE, 64'h1234_0001, 16'd0, 16'sd0, 8'sd6, BOUND_EXACT, -16'sd9, 16'sd9);
      send_beat(OP_STORE, 64'h1234_0001, 16'h1111, 16'sd50, 8'sd4, BOUND_EXACT,
                16'sd0, 16'sd0);
      send_beat(OP_STORE, 64'h1234_0001, 16'h2222, -16'sd60, 8'sd5, BOUND_EXACT,
                16'sd0, 16'sd0);
      send_beat(OP_STORE, 64'h9999_0001, 16'h3333, 16'sd1, -8'sd3, BOUND_EXACT,
                16'sd0, 16'sd0);
      // lower bound raising alpha, with and without closing the window
      send_beat(OP_STORE, 64'hbeef_0002, 16'h0202, 16'sd200, 8'sd3, BOUND_LOWER,
                16'sd0, 16'sd0);
      send_beat(OP_PROBE, 64'hbeef_0002, 16'd0, 16'sd0, 8'sd2, BOUND_EXACT, -16'sd100,
                16'sd150);
      send_beat(OP_PROBE, 64'hbeef_0002, 16'd0, 16'sd0, 8'sd3, BOUND_EXACT, -16'sd100,
                16'sd300);
      // upper bound lowering beta
      send_beat(OP_STORE, 64'hcafe_0003, 16'h0303, -16'sd50, 8'sd2, BOUND_UPPER,
                16'sd0, 16'sd0);
      send_beat(OP_PROBE, 64'hcafe_0003, 16'd0, 16'sd0, 8'sd1, BOUND_EXACT, 16'sd0, 16'sd100);
      send_beat(OP_PROBE, 64'hcafe_0003, 16'd0, 16'sd0, 8'sd2, BOUND_EXACT, -16'sd200,
                16'sd100);
      // bound kind three: only an already closed window cuts off
      send_beat(OP_STORE, 64'hd00d_0004, 16'h0404, 16'sd77, 8'sd1, 2'd3, 16'sd0, 16'sd0);
      send_beat(OP_PROBE, 64'hd00d_0004, 16'd0, 16'sd0, 8'sd0, BOUND_EXACT, 16'sd10, 16'sd10);
      send_beat(OP_PROBE, 64'hd00d_0004, 16'd0, 16'sd0, 8'sd0, BOUND_EXACT, 16'sd0, 16'sd5);
      // field extremes
      send_beat(OP_STORE, '1, 16'hffff, 16'sd32767, 8'sd127, BOUND_LOWER, 16'sd0, 16'sd0);
      send_beat(OP_PROBE, '1, 16'd0, 16'sd0, 8'sd127, BOUND_EXACT, -16'sd32767, 16'sd32767);
      send_beat(OP_STORE, 64'h8000_0000_0000_0fff, 16'h8000, -16'sd32767, -8'sd128,
                BOUND_UPPER, 16'sd0, 16'sd0);
      send_beat(OP_PROBE, 64'h8000_0000_0000_0fff, 16'hffff, 16'sd0, -8'sd128, 2'd3,
                -16'sd32767, 16'sd32767);
      send_beat(OP_STORE, 64'h8000_0000_0000_0fff, 16'h00ff, 16'sd0, 8'sd127, BOUND_EXACT,
                16'sd32767, -16'sd32767);

      repeat (RANDOM_BEATS) send_random_beat();

      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("transposition_table_probe_store_tb passed");
      end else begin
         $display("transposition_table_probe_store_tb failed");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/ttps_pkg.sv
rtl/ttps_ram.sv
rtl/ttps_ctrl.sv
rtl/ttps_dp.sv
rtl/transposition_table_probe_store.sv
verif/transposition_table_probe_store_checker.sv
verif/transposition_table_probe_store_tb.sv
